/* rtl/mtt_pkg.sv */
`default_nettype none

package mtt_pkg;

  // sizes and defaults
  localparam int unsigned QueueDepthDef = 128;
  localparam int unsigned AddrW         = 5;
  localparam int unsigned DataW         = 32;
  localparam int unsigned WidthT0       = 7;
  localparam int unsigned WidthT1       = 5;

  localparam logic [5:0]  MaskT0        = 6'h3F;
  localparam logic [5:0]  MaskT1        = 6'h0F;
  localparam logic [6:0]  CodeMaskT0    = 7'h7F;
  localparam logic [6:0]  CodeMaskT1    = 7'h1F;

  localparam logic [15:0] FullDef       = 16'd200;
  localparam logic [15:0] HalfDef       = 16'd100;
  localparam logic [7:0]  LeadDef       = 8'd25;
  localparam logic [7:0]  TrailT0Def    = 8'd28;
  localparam logic [7:0]  TrailT1Def    = 8'd25;

  // request kinds
  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_PUSH = 1'b1
  } cmd_e;

  // register map, one word each
  typedef enum logic [2:0] {
    REG_FULL_T0  = 3'd0,
    REG_HALF_T0  = 3'd1,
    REG_FULL_T1  = 3'd2,
    REG_HALF_T1  = 3'd3,
    REG_LEAD_T0  = 3'd4,
    REG_TRAIL_T0 = 3'd5,
    REG_LEAD_T1  = 3'd6,
    REG_TRAIL_T1 = 3'd7
  } cfg_reg_e;

  // frame phases, one-hot
  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_LEAD  = 5'b00010,
    PH_DATA  = 5'b00100,
    PH_LRC   = 5'b01000,
    PH_TRAIL = 5'b10000
  } phase_e;

  typedef struct packed {
    logic       track;
    logic       last;
    logic [6:0] code;
  } entry_t;

  typedef struct packed {
    logic   is_push;
    entry_t entry;
  } req_t;

  typedef struct packed {
    logic [1:0][15:0] full;
    logic [1:0][15:0] half;
    logic [1:0][7:0]  lead;
    logic [1:0][7:0]  trail;
  } cfg_t;

  typedef struct packed {
    logic push;
    logic pop;
  } qctl_t;

  typedef struct packed {
    logic nonempty;
    logic full;
  } qstat_t;

  // lrc character: odd column parity, top bit set on an even count of ones
  function automatic logic [6:0] lrc_calc(input logic [5:0] par, input logic trk);
    logic [5:0] d;
    logic [6:0] r;
    d = ~par & (trk ? MaskT1 : MaskT0);
    r = {1'b0, d};
    if (!(^d)) begin
      if (trk) begin
        r[4] = 1'b1;
      end else begin
        r[6] = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/mtt_if.sv */
`default_nettype none

// request channel
interface mtt_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic       track;
  logic [6:0] code;
  logic       last;

  modport source (output valid, output cmd, output track, output code, output last,
                  input ready);
  modport sink   (input valid, input cmd, input track, input code, input last,
                  output ready);
endinterface

// result channel
interface mtt_out_if;
  logic valid;
  logic ready;
  logic coil;
  logic accepted;
  logic busy_res;
  logic bit_start;
  logic frame_done;

  modport source (output valid, output coil, output accepted, output busy_res,
                  output bit_start, output frame_done, input ready);
  modport sink   (input valid, input coil, input accepted, input busy_res,
                  input bit_start, input frame_done, output ready);
endinterface

`default_nettype wire

/* rtl/mtt_front.sv */
`default_nettype none

module mtt_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  mtt_in_if.sink        in_if,
  output logic          req_valid_o,
  output mtt_pkg::req_t req_o,
  input  logic          req_ready_i
);
  import mtt_pkg::*;

  req_t       buf_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       take, give;
  req_t       req_in;

  // classify the incoming request
  always_comb begin
    req_in.is_push     = (cmd_e'(in_if.cmd) == CMD_PUSH);
    req_in.entry.track = in_if.track;
    req_in.entry.last  = in_if.last;
    req_in.entry.code  = in_if.code;
  end

  assign in_if.ready = (cnt_q != 2'd2);
  assign take        = in_if.valid && in_if.ready;
  assign req_valid_o = (cnt_q != 2'd0);
  assign req_o       = buf_q[rd_q];
  assign give        = req_valid_o && req_ready_i;

  // two-entry request queue towards the driver
  always_ff @(posedge clk_i) begin
    if (take) begin
      buf_q[wr_q] <= req_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (take) begin
        wr_q <= ~wr_q;
      end
      if (give) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, take} - {1'b0, give};
    end
  end

endmodule

`default_nettype wire

/* rtl/mtt_code_fifo.sv */
`default_nettype none

module mtt_code_fifo #(
  parameter int unsigned QUEUE_DEPTH = mtt_pkg::QueueDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mtt_pkg::qctl_t  ctl_i,
  input  mtt_pkg::entry_t wdata_i,
  output mtt_pkg::entry_t head_o,
  output mtt_pkg::qstat_t stat_o
);
  import mtt_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  entry_t          mem_q [QUEUE_DEPTH];
  entry_t          rd_data_q;
  logic [PtrW-1:0] head_q, tail_q, head_nxt, tail_nxt, rd_addr;
  logic [CntW-1:0] count_q;

  // pointer wrap for any depth
  assign head_nxt = (head_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_nxt = (tail_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
  assign rd_addr  = ctl_i.pop ? head_nxt : head_q;

  // code storage
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem_q[tail_q] <= wdata_i;
    end
  end

  // head prefetch, with write bypass into an empty or emptying queue
  always_ff @(posedge clk_i) begin
    if (ctl_i.push && (tail_q == rd_addr)) begin
      rd_data_q <= wdata_i;
    end else begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      if (ctl_i.push) begin
        tail_q <= tail_nxt;
      end
      if (ctl_i.pop) begin
        head_q <= head_nxt;
      end
      count_q <= count_q + CntW'(ctl_i.push) - CntW'(ctl_i.pop);
    end
  end

  assign head_o          = rd_data_q;
  assign stat_o.nonempty = (count_q != '0);
  assign stat_o.full     = (count_q == CntW'(QUEUE_DEPTH));

  // checks
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.push |-> !stat_o.full) else $error("push into a full code queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.pop |-> stat_o.nonempty) else $error("pop from an empty code queue");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (head_q == tail_q)) else $error("empty queue with split pointers");

endmodule

`default_nettype wire

/* rtl/mtt_back.sv */
`default_nettype none

module mtt_back #(
  parameter int unsigned QUEUE_DEPTH = mtt_pkg::QueueDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mtt_pkg::cfg_t cfg_i,
  input  logic          req_valid_i,
  input  mtt_pkg::req_t req_i,
  output logic          req_ready_o,
  mtt_out_if.source     out_if
);
  import mtt_pkg::*;

  typedef struct packed {
    phase_e     phase;
    logic [7:0] zc;
    logic [2:0] idx;
    logic [6:0] shift;
    logic [5:0] par;
    logic       trk;
    logic       last;
  } drv_t;

  typedef struct packed {
    logic coil;
    logic accepted;
    logic busy_res;
    logic bit_start;
    logic frame_done;
  } res_t;

  drv_t        st_q, st_d, sf_s, nb_in, nb_out;
  logic        coil_q, coil_d;
  logic [15:0] bit_timer_q, bit_timer_d, mid_timer_q, mid_timer_d;
  logic        out_valid_q;
  res_t        res_q, res_d;
  logic        proc, ends, use_sf, nb_bit, nb_pop;
  logic [2:0]  cur_w;
  qctl_t       qctl;
  qstat_t      qstat;
  entry_t      head;

  mtt_code_fifo #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_code_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (qctl),
    .wdata_i (req_i.entry),
    .head_o  (head),
    .stat_o  (qstat)
  );

  assign req_ready_o = !out_valid_q || out_if.ready;
  assign proc        = req_valid_i && req_ready_o;

  // frame end: trail zeros used up, or lrc done with no trail
  assign cur_w  = st_q.trk ? 3'(WidthT1) : 3'(WidthT0);
  assign ends   = ((st_q.phase == PH_TRAIL) && (st_q.zc == '0)) ||
                  ((st_q.phase == PH_LRC) && (st_q.idx >= cur_w) &&
                   (cfg_i.trail[st_q.trk] == '0));
  assign use_sf = (st_q.phase == PH_IDLE) || ends;

  // state at the start of a new frame, taken from the head code
  always_comb begin
    sf_s.phase = PH_LEAD;
    sf_s.zc    = cfg_i.lead[head.track];
    sf_s.idx   = '0;
    sf_s.shift = '0;
    sf_s.par   = '0;
    sf_s.trk   = head.track;
    sf_s.last  = 1'b0;
  end

  assign nb_in = use_sf ? sf_s : st_q;

  // next bit sequencer: at most one phase step and one code load
  always_comb begin
    logic [2:0] w;
    logic [5:0] mask;
    logic [6:0] ld_code, lrc;
    logic       do_load, do_lrc;
    w       = nb_in.trk ? 3'(WidthT1) : 3'(WidthT0);
    mask    = nb_in.trk ? MaskT1 : MaskT0;
    ld_code = head.code & (nb_in.trk ? CodeMaskT1 : CodeMaskT0);
    lrc     = lrc_calc(nb_in.par, nb_in.trk);
    nb_out  = nb_in;
    nb_bit  = 1'b0;
    nb_pop  = 1'b0;
    do_load = 1'b0;
    do_lrc  = 1'b0;
    case (nb_in.phase)
      PH_LEAD: begin
        if (nb_in.zc != '0) begin
          nb_out.zc = nb_in.zc - 8'd1;
        end else if (qstat.nonempty) begin
          do_load = 1'b1;
        end else begin
          do_lrc = 1'b1;
        end
      end
      PH_DATA: begin
        if (nb_in.idx < w) begin
          nb_bit     = nb_in.shift[nb_in.idx];
          nb_out.idx = nb_in.idx + 3'd1;
        end else if (nb_in.last || !qstat.nonempty) begin
          do_lrc = 1'b1;
        end else begin
          do_load = 1'b1;
        end
      end
      PH_LRC: begin
        if (nb_in.idx < w) begin
          nb_bit     = nb_in.shift[nb_in.idx];
          nb_out.idx = nb_in.idx + 3'd1;
        end else begin
          nb_out.phase = PH_TRAIL;
          nb_out.zc    = cfg_i.trail[nb_in.trk] - 8'd1;
        end
      end
      PH_TRAIL: begin
        nb_out.zc = nb_in.zc - 8'd1;
      end
      default: begin
        nb_out = nb_in;
      end
    endcase
    // fetch the next character from the queue
    if (do_load) begin
      nb_out.phase = PH_DATA;
      nb_out.shift = ld_code;
      nb_out.last  = head.last;
      nb_out.par   = nb_in.par ^ (ld_code[5:0] & mask);
      nb_out.idx   = 3'd1;
      nb_bit       = ld_code[0];
      nb_pop       = 1'b1;
    end
    // close the data with the lrc character
    if (do_lrc) begin
      nb_out.phase = PH_LRC;
      nb_out.shift = lrc;
      nb_out.idx   = 3'd1;
      nb_bit       = lrc[0];
    end
  end

  // request execution
  always_comb begin
    logic [15:0] bt_dec;
    logic        do_bit;
    logic        done;
    logic [15:0] full;
    st_d        = st_q;
    coil_d      = coil_q;
    bit_timer_d = bit_timer_q;
    mid_timer_d = mid_timer_q;
    qctl        = '0;
    do_bit      = 1'b0;
    done        = 1'b0;
    res_d       = '0;
    bt_dec      = (bit_timer_q != '0) ? bit_timer_q - 16'd1 : '0;
    full        = cfg_i.full[nb_out.trk];
    if (proc) begin
      if (req_i.is_push) begin
        if (!qstat.full) begin
          qctl.push      = 1'b1;
          res_d.accepted = 1'b1;
        end
      end else if (st_q.phase == PH_IDLE) begin
        do_bit = qstat.nonempty;
      end else if (bt_dec != '0) begin
        bit_timer_d = bt_dec;
        if (mid_timer_q != '0) begin
          mid_timer_d = mid_timer_q - 16'd1;
          if (mid_timer_q == 16'd1) begin
            coil_d = ~coil_q;
          end
        end
      end else if (!ends) begin
        do_bit = 1'b1;
      end else begin
        done        = 1'b1;
        st_d.phase  = PH_IDLE;
        mid_timer_d = '0;
        if (qstat.nonempty) begin
          do_bit = 1'b1;
        end else begin
          coil_d = 1'b0;
        end
      end
      // start of a bit period
      if (do_bit) begin
        st_d        = nb_out;
        coil_d      = ~coil_q;
        bit_timer_d = (full != '0) ? full : 16'd1;
        mid_timer_d = nb_bit ? cfg_i.half[nb_out.trk] : '0;
        qctl.pop    = nb_pop;
      end
    end
    res_d.coil       = coil_d;
    res_d.busy_res   = (st_d.phase != PH_IDLE);
    res_d.bit_start  = do_bit;
    res_d.frame_done = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= '{phase: PH_IDLE, default: '0};
      coil_q      <= 1'b0;
      bit_timer_q <= '0;
      mid_timer_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (proc) begin
        st_q        <= st_d;
        coil_q      <= coil_d;
        bit_timer_q <= bit_timer_d;
        mid_timer_q <= mid_timer_d;
      end
      if (req_ready_o) begin
        out_valid_q <= req_valid_i;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (proc) begin
      res_q <= res_d;
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.coil       = res_q.coil;
  assign out_if.accepted   = res_q.accepted;
  assign out_if.busy_res   = res_q.busy_res;
  assign out_if.bit_start  = res_q.bit_start;
  assign out_if.frame_done = res_q.frame_done;

  // checks
  a_idle_no_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.phase == PH_IDLE) |-> (mid_timer_q == '0)) else $error("mid toggle pending while idle");

  a_busy_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.phase != PH_IDLE) |-> (bit_timer_q != '0)) else $error("bit timer empty in a frame");

  a_tick_not_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && !req_i.is_push) |=> !res_q.accepted) else $error("tick reported as accepted");

  a_end_coil_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.frame_done && !res_q.busy_res) |-> !res_q.coil)
    else $error("coil left high after the last frame");

endmodule

`default_nettype wire

/* rtl/mtt_cfg.sv */
`default_nettype none

module mtt_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel_i,
  input  logic                      penable_i,
  input  logic                      pwrite_i,
  input  logic [mtt_pkg::AddrW-1:0] paddr_i,
  input  logic [mtt_pkg::DataW-1:0] pwdata_i,
  output logic [mtt_pkg::DataW-1:0] prdata_o,
  output logic                      pready_o,
  output mtt_pkg::cfg_t             cfg_o
);
  import mtt_pkg::*;

  cfg_t     cfg_q;
  cfg_reg_e reg_idx;
  logic     wr_en;

  assign reg_idx  = cfg_reg_e'(paddr_i[AddrW-1:2]);
  assign pready_o = 1'b1;
  assign wr_en    = psel_i && penable_i && pwrite_i && pready_o;
  assign cfg_o    = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.full  <= {FullDef, FullDef};
      cfg_q.half  <= {HalfDef, HalfDef};
      cfg_q.lead  <= {LeadDef, LeadDef};
      cfg_q.trail <= {TrailT1Def, TrailT0Def};
    end else if (wr_en) begin
      case (reg_idx)
        REG_FULL_T0:  cfg_q.full[0]  <= pwdata_i[15:0];
        REG_HALF_T0:  cfg_q.half[0]  <= pwdata_i[15:0];
        REG_FULL_T1:  cfg_q.full[1]  <= pwdata_i[15:0];
        REG_HALF_T1:  cfg_q.half[1]  <= pwdata_i[15:0];
        REG_LEAD_T0:  cfg_q.lead[0]  <= pwdata_i[7:0];
        REG_TRAIL_T0: cfg_q.trail[0] <= pwdata_i[7:0];
        REG_LEAD_T1:  cfg_q.lead[1]  <= pwdata_i[7:0];
        REG_TRAIL_T1: cfg_q.trail[1] <= pwdata_i[7:0];
        default:      cfg_q          <= cfg_q;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      REG_FULL_T0:  prdata_o = DataW'(cfg_q.full[0]);
      REG_HALF_T0:  prdata_o = DataW'(cfg_q.half[0]);
      REG_FULL_T1:  prdata_o = DataW'(cfg_q.full[1]);
      REG_HALF_T1:  prdata_o = DataW'(cfg_q.half[1]);
      REG_LEAD_T0:  prdata_o = DataW'(cfg_q.lead[0]);
      REG_TRAIL_T0: prdata_o = DataW'(cfg_q.trail[0]);
      REG_LEAD_T1:  prdata_o = DataW'(cfg_q.lead[1]);
      REG_TRAIL_T1: prdata_o = DataW'(cfg_q.trail[1]);
      default:      prdata_o = '0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/magstripe_track_transmitter_top.sv */
// a request's result is offered from the result register, once it has passed the
//   two-entry intake queue and the coil driver; either can be held by back-pressure
// throughput: while out_if is ready, one request per cycle, ticks and pushes alike; the coil
//   driver retires one request a cycle and reads the code queue through a prefetched head
// reset: timing registers take their defaults, code queue empty, driver idle, coil low
// the code queue memory itself is not cleared; an entry is read only after it is written
`default_nettype none

module magstripe_track_transmitter_top #(
  parameter int unsigned QUEUE_DEPTH = mtt_pkg::QueueDepthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [mtt_pkg::AddrW-1:0] paddr,
  input  logic [mtt_pkg::DataW-1:0] pwdata,
  output logic [mtt_pkg::DataW-1:0] prdata,
  output logic                      pready,
  mtt_in_if.sink                    in_if,
  mtt_out_if.source                 out_if
);
  import mtt_pkg::*;

  cfg_t cfg;
  req_t req;
  logic req_valid, req_ready;

  // configuration registers
  mtt_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  // request intake
  mtt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .req_valid_o (req_valid),
    .req_o       (req),
    .req_ready_i (req_ready)
  );

  // code queue and coil driver
  mtt_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .req_valid_i (req_valid),
    .req_i       (req),
    .req_ready_o (req_ready),
    .out_if      (out_if)
  );

endmodule

`default_nettype wire
